// File: rtl/core/positional_list_store_assert.svh
// Assertion macros shared by the list store RTL.
`ifndef POSITIONAL_LIST_STORE_ASSERT_SVH
`define POSITIONAL_LIST_STORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define PLS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("list store check failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define PLS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("list store check failed");

`endif

// File: rtl/core/pls_pkg.sv
`timescale 1ns / 1ps

package pls_pkg;

    // List capacity and derived widths
    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = ((CNT_W > 5) ? CNT_W : 5) + 1;

    // Field widths of the channels
    localparam int FUNC_W  = 3;
    localparam int POS_W   = 5;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 48;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_FIND   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_TEST   = 3'd4;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_RANGE    = 2'd2,
        STAT_NOTFOUND = 2'd3
    } status_t;

endpackage

// File: rtl/core/positional_list_store.sv
`timescale 1ns / 1ps

// Ordered list of up to DEPTH signed 32-bit values, positions counted from 1.
// Input transfer: s_tuser carries the operation (insert, remove, read, find,
// test), s_tdata carries the position and the value. One result transfer on
// the m_ side per input: read value, found position, present flag, count
// after the operation, empty flag and a status code (ok, full, position out
// of range, value not found).
// The list sits in a memory with one write port and one registered read port;
// every entry touched takes a read state and then a write or compare state.
// Insert moves the entries from the position to the end up one place, top
// first, then writes the value; remove moves the entries behind the position
// down one place; read fetches one entry; find and test scan from the front
// to the first match; a rejected item or an unused code goes straight to the
// result. s_tready rises the cycle after the result is registered. One item is
// worked at a time; s_tready is low while it runs. A finished result waits in
// the output register while the next item is taken; if m_tready stays low the
// sequencer holds at the end of that next item. Synchronous reset empties the
// list and drops any result.
module positional_list_store
    import pls_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // position[4:0], value[36:5], zero fill
    input  logic [FUNC_W-1:0]   s_tuser,   // func[2:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // read_value[31:0], found_position[36:32],
                                           // present[37], count[42:38], empty_res[43],
                                           // status[45:44], zero fill
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_REM_RD,
        S_REM_WR,
        S_REM_FIN,
        S_RD_ISSUE,
        S_RD_TAKE,
        S_FND_RD,
        S_FND_CMP,
        S_DONE
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     idx_reg;
    logic [FUNC_W-1:0]    func_reg;
    logic [CMP_W-1:0]     pos_reg;
    logic [VAL_W-1:0]     val_reg;
    logic [VAL_W-1:0]     rd_reg;
    logic [POS_W-1:0]     fp_reg;
    logic                 pres_reg;
    status_t              stat_reg;
    logic                 m_tvalid_reg;
    logic [M_DATA_W-1:0]  m_tdata_reg;

    logic [VAL_W-1:0]     mem [DEPTH];
    logic [VAL_W-1:0]     rdata_reg;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [VAL_W-1:0]     mem_wdata;
    logic [IDX_W-1:0]     mem_raddr;

    logic [CMP_W-1:0]     count_ext;
    logic [CMP_W-1:0]     idx_ext;
    logic [CMP_W-1:0]     idx_dec;
    logic [CMP_W-1:0]     idx_inc;
    logic [CMP_W-1:0]     pos_dec;
    logic [CMP_W-1:0]     ins_pos;
    logic [CMP_W-1:0]     cnt_out;
    logic                 s_xfer;
    logic                 out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign count_ext = CMP_W'(count_reg);
    assign idx_ext   = CMP_W'(idx_reg);
    assign idx_dec   = idx_ext - CMP_W'(1);
    assign idx_inc   = idx_ext + CMP_W'(1);
    assign pos_dec   = pos_reg - CMP_W'(1);
    assign ins_pos   = (count_reg == '0) ? CMP_W'(1) : pos_reg;
    assign cnt_out   = count_ext;

    // Drive the memory port from the sequencer state
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg[IDX_W-1:0];
        mem_wdata = rdata_reg;
        mem_raddr = idx_reg[IDX_W-1:0];
        unique case (state_reg)
            S_INS_RD: begin
                mem_raddr = idx_dec[IDX_W-1:0];
            end
            S_INS_WR: begin
                mem_we = 1'b1;
            end
            S_INS_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = pos_dec[IDX_W-1:0];
                mem_wdata = val_reg;
            end
            S_REM_WR: begin
                mem_we    = 1'b1;
                mem_waddr = idx_dec[IDX_W-1:0];
            end
            S_RD_ISSUE: begin
                mem_raddr = pos_dec[IDX_W-1:0];
            end
            default: begin
            end
        endcase
    end

    // Element memory with registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    // Sequencer, list count and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // Drop the result once the sink takes it, unless a new one replaces it
            if (m_tvalid_reg && m_tready && state_reg != S_DONE) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_xfer) begin
                        func_reg  <= s_tuser;
                        pos_reg   <= CMP_W'(s_tdata[POS_W-1:0]);
                        val_reg   <= s_tdata[POS_W +: VAL_W];
                        rd_reg    <= '0;
                        fp_reg    <= '0;
                        pres_reg  <= 1'b0;
                        stat_reg  <= STAT_OK;
                        state_reg <= S_DECIDE;
                    end
                end

                S_DECIDE: begin
                    priority if (func_reg == FUNC_INSERT) begin
                        if (count_ext >= CMP_W'(DEPTH)) begin
                            stat_reg  <= STAT_FULL;
                            state_reg <= S_DONE;
                        end else if (ins_pos == '0 || ins_pos > count_ext + CMP_W'(1)) begin
                            stat_reg  <= STAT_RANGE;
                            state_reg <= S_DONE;
                        end else begin
                            pos_reg   <= ins_pos;
                            idx_reg   <= count_reg;
                            state_reg <= (count_ext >= ins_pos) ? S_INS_RD : S_INS_PUT;
                        end
                    end else if (func_reg == FUNC_REMOVE) begin
                        if (pos_reg == '0 || pos_reg > count_ext) begin
                            stat_reg  <= STAT_RANGE;
                            state_reg <= S_DONE;
                        end else begin
                            idx_reg   <= pos_reg[CNT_W-1:0];
                            state_reg <= (pos_reg < count_ext) ? S_REM_RD : S_REM_FIN;
                        end
                    end else if (func_reg == FUNC_READ) begin
                        if (pos_reg == '0 || pos_reg > count_ext) begin
                            stat_reg  <= STAT_RANGE;
                            state_reg <= S_DONE;
                        end else begin
                            state_reg <= S_RD_ISSUE;
                        end
                    end else if (func_reg == FUNC_FIND || func_reg == FUNC_TEST) begin
                        idx_reg <= '0;
                        if (count_reg == '0) begin
                            if (func_reg == FUNC_FIND) begin
                                stat_reg <= STAT_NOTFOUND;
                            end
                            state_reg <= S_DONE;
                        end else begin
                            state_reg <= S_FND_RD;
                        end
                    end else begin
                        state_reg <= S_DONE;
                    end
                end

                // Move entries up one place, top first
                S_INS_RD: begin
                    state_reg <= S_INS_WR;
                end
                S_INS_WR: begin
                    idx_reg   <= idx_dec[CNT_W-1:0];
                    state_reg <= (idx_ext > pos_reg) ? S_INS_RD : S_INS_PUT;
                end
                S_INS_PUT: begin
                    count_reg <= count_reg + CNT_W'(1);
                    state_reg <= S_DONE;
                end

                // Move entries down one place, bottom first
                S_REM_RD: begin
                    state_reg <= S_REM_WR;
                end
                S_REM_WR: begin
                    idx_reg   <= idx_inc[CNT_W-1:0];
                    state_reg <= (idx_inc < count_ext) ? S_REM_RD : S_REM_FIN;
                end
                S_REM_FIN: begin
                    count_reg <= count_reg - CNT_W'(1);
                    state_reg <= S_DONE;
                end

                // Fetch one entry
                S_RD_ISSUE: begin
                    state_reg <= S_RD_TAKE;
                end
                S_RD_TAKE: begin
                    rd_reg    <= rdata_reg;
                    state_reg <= S_DONE;
                end

                // Scan from the front for the first match
                S_FND_RD: begin
                    state_reg <= S_FND_CMP;
                end
                S_FND_CMP: begin
                    if (rdata_reg == val_reg) begin
                        fp_reg    <= idx_inc[POS_W-1:0];
                        pres_reg  <= 1'b1;
                        state_reg <= S_DONE;
                    end else if (idx_inc < count_ext) begin
                        idx_reg   <= idx_inc[CNT_W-1:0];
                        state_reg <= S_FND_RD;
                    end else begin
                        if (func_reg == FUNC_FIND) begin
                            stat_reg <= STAT_NOTFOUND;
                        end
                        state_reg <= S_DONE;
                    end
                end

                // Hand the result to the output register once it is free
                S_DONE: begin
                    if (out_free) begin
                        m_tdata_reg  <= {2'b00, stat_reg, (count_reg == '0),
                                         cnt_out[POS_W-1:0], pres_reg, fp_reg, rd_reg};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end

                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`include "positional_list_store_assert.svh"

    // Count stays within capacity
    `PLS_ASSERT_NOW(a_count_cap, aclk, aresetn, 1'b1, count_ext <= CMP_W'(DEPTH))

    // Count moves only when an insert or remove completes
    `PLS_ASSERT_NEXT(a_count_hold, aclk, aresetn,
                     state_reg != S_INS_PUT && state_reg != S_REM_FIN, $stable(count_reg))

    // Memory is written only while shifting or placing a value
    `PLS_ASSERT_NOW(a_write_phase, aclk, aresetn, mem_we,
                    state_reg == S_INS_WR || state_reg == S_INS_PUT || state_reg == S_REM_WR)

    // A full status carries a full count
    `PLS_ASSERT_NOW(a_full_status, aclk, aresetn,
                    m_tvalid_reg && m_tdata_reg[45:44] == STAT_FULL,
                    m_tdata_reg[42:38] == POS_W'(DEPTH))

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import pls_pkg::*;

    // Unused operation codes above the last defined one
    localparam logic [FUNC_W-1:0] FUNC_LAST = 3'd7;

    // Traffic mixes for the random bursts
    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIX   = 2;

    localparam int BURST_LEN    = 30;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 12;
    localparam int MAX_PRINTED  = 30;

    typedef struct {
        logic [VAL_W-1:0] read_value;
        logic [4:0]       found_position;
        logic             present;
        logic [4:0]       count;
        logic             empty_res;
        status_t          status;
    } list_result_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [FUNC_W-1:0]   s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // Shadow copy of the list, updated as each transfer is accepted
    logic [VAL_W-1:0] list_vals [DEPTH];
    int               list_len = 0;

    list_result_t pending_results [$];
    int           mismatch_count = 0;

    // Idle rates and the long receiver hold-off, set by the stimulus
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off_len = 0;
    int hold_off_seq = 0;

    positional_list_store DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Apply one operation to the shadow list and return the result it must produce
    function automatic list_result_t apply_list_op(input logic [FUNC_W-1:0] op,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic [VAL_W-1:0] val);
        list_result_t r;
        int p;
        int i;
        int hit;
        r.read_value     = '0;
        r.found_position = '0;
        r.present        = 1'b0;
        r.status         = STAT_OK;
        p   = pos;
        hit = 0;
        case (op)
            FUNC_INSERT: begin
                if (list_len >= DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    // an empty list always takes the value at the head
                    if (list_len == 0)
                        p = 1;
                    if (p < 1 || p > list_len + 1) begin
                        r.status = STAT_RANGE;
                    end else begin
                        for (i = list_len; i >= p; i--)
                            list_vals[i] = list_vals[i-1];
                        list_vals[p-1] = val;
                        list_len++;
                    end
                end
            end
            FUNC_REMOVE: begin
                if (p < 1 || p > list_len) begin
                    r.status = STAT_RANGE;
                end else begin
                    for (i = p; i < list_len; i++)
                        list_vals[i-1] = list_vals[i];
                    list_len--;
                end
            end
            FUNC_READ: begin
                if (p < 1 || p > list_len)
                    r.status = STAT_RANGE;
                else
                    r.read_value = list_vals[p-1];
            end
            FUNC_FIND, FUNC_TEST: begin
                for (i = 0; i < list_len && hit == 0; i++) begin
                    if (list_vals[i] == val)
                        hit = i + 1;
                end
                r.found_position = hit[4:0];
                r.present        = (hit != 0);
                if (op == FUNC_FIND && hit == 0)
                    r.status = STAT_NOTFOUND;
            end
            default: begin
            end
        endcase
        r.count     = list_len[4:0];
        r.empty_res = (list_len == 0);
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("%0t ns: mismatch on %s, got %h, want %h", $time, what, got, want);
    endtask

    // Offer one item, with random idle cycles ahead of it, and log its result on transfer
    task automatic send_op(input logic [FUNC_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic [VAL_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_DATA_W - POS_W - VAL_W){1'b0}}, val, pos};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        pending_results.push_back(apply_list_op(op, pos, val));
    endtask

    // Pick an operation biased by the traffic mix, mostly with in-range positions
    task automatic send_random_op(input int mode);
        logic [FUNC_W-1:0] op;
        logic [POS_W-1:0]  pos;
        logic [VAL_W-1:0]  val;
        int ins_w;
        int rem_w;
        int roll;
        int top;
        ins_w = (mode == MODE_FILL) ? 60 : (mode == MODE_DRAIN) ? 12 : 30;
        rem_w = (mode == MODE_FILL) ? 10 : (mode == MODE_DRAIN) ? 55 : 22;
        roll  = $urandom_range(99);
        if (roll < ins_w) begin
            op = FUNC_INSERT;
        end else if (roll < ins_w + rem_w) begin
            op = FUNC_REMOVE;
        end else begin
            roll = $urandom_range(99);
            if (roll < 38)
                op = FUNC_READ;
            else if (roll < 69)
                op = FUNC_FIND;
            else if (roll < 97)
                op = FUNC_TEST;
            else
                op = FUNC_W'($urandom_range(FUNC_TEST + 1, FUNC_LAST));
        end

        top = list_len + ((op == FUNC_INSERT) ? 1 : 0);
        if (top > 0 && $urandom_range(99) < 80)
            pos = POS_W'($urandom_range(1, top));
        else
            pos = POS_W'($urandom_range(0, 31));

        // favor stored values for lookups and a small pool for duplicates
        roll = $urandom_range(99);
        if ((op == FUNC_FIND || op == FUNC_TEST) && list_len > 0 && roll < 60) begin
            val = list_vals[$urandom_range(0, list_len - 1)];
        end else if (roll < 70) begin
            case ($urandom_range(0, 7))
                0: val = 32'h0000_0000;
                1: val = 32'hFFFF_FFFF;
                2: val = 32'h8000_0000;
                3: val = 32'h7FFF_FFFF;
                4: val = 32'h0000_0001;
                5: val = 32'h5A5A_5A5A;
                6: val = 32'hA5A5_A5A5;
                default: val = 32'h0001_0000;
            endcase
        end else begin
            val = $urandom;
        end
        send_op(op, pos, val);
    endtask

    task automatic test_empty_list();
        send_op(FUNC_REMOVE, 5'd1, 32'h0);
        send_op(FUNC_READ,   5'd1, 32'h0);
        send_op(FUNC_FIND,   5'd0, 32'h0);
        send_op(FUNC_TEST,   5'd0, 32'h0);
    endtask

    task automatic test_insert_positions();
        send_op(FUNC_INSERT, 5'd31, 32'h7FFF_FFFF);   // empty list: lands at the head
        send_op(FUNC_INSERT, 5'd0,  32'h1111_1111);
        send_op(FUNC_INSERT, 5'd1,  32'h8000_0000);
        send_op(FUNC_INSERT, 5'd3,  32'hFFFF_FFFF);   // append at count + 1
        send_op(FUNC_INSERT, 5'd5,  32'h2222_2222);   // one past the append slot
        send_op(FUNC_INSERT, 5'd2,  32'h0000_0000);
    endtask

    task automatic test_read_and_lookup();
        send_op(FUNC_READ,   5'd0, 32'h0);
        send_op(FUNC_READ,   5'd4, 32'h0);
        send_op(FUNC_READ,   5'd5, 32'h0);
        send_op(FUNC_FIND,   5'd0, 32'h0000_0000);
        send_op(FUNC_FIND,   5'd0, 32'h1234_5678);
        send_op(FUNC_TEST,   5'd0, 32'h7FFF_FFFF);
        send_op(FUNC_TEST,   5'd0, 32'h0000_0001);
        // a duplicate at the tail must not move the first match
        send_op(FUNC_INSERT, 5'd5, 32'h0000_0000);
        send_op(FUNC_FIND,   5'd0, 32'h0000_0000);
    endtask

    task automatic test_remove_positions();
        send_op(FUNC_REMOVE, 5'd0, 32'h0);
        send_op(FUNC_REMOVE, 5'd6, 32'h0);
        send_op(FUNC_REMOVE, 5'd5, 32'h0);
        send_op(FUNC_REMOVE, 5'd1, 32'h0);
    endtask

    task automatic test_unused_funcs();
        int f;
        for (f = FUNC_TEST + 1; f <= FUNC_LAST; f++)
            send_op(FUNC_W'(f), 5'd1, 32'hDEAD_BEEF);
    endtask

    // Random traffic in bursts that fill, drain or mix the list
    task automatic test_list_traffic(input int n_items, input int tx_idle, input int rx_idle);
        int n;
        int mode;
        send_idle_pct = tx_idle;
        recv_idle_pct = rx_idle;
        mode = MODE_MIX;
        for (n = 0; n < n_items; n++) begin
            if (n % BURST_LEN == 0)
                mode = $urandom_range(MODE_FILL, MODE_MIX);
            send_random_op(mode);
        end
    endtask

    // Hold the result side off while items keep coming, so the input stalls
    task automatic test_backpressure();
        int n;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_len  = 300;
        hold_off_seq++;
        for (n = 0; n < 40; n++)
            send_random_op(MODE_MIX);
    endtask

    // Drive m_tready: random idling, or a counted hold-off when one is requested
    always @(posedge aclk) begin : drive_ready
        int seen_seq;
        int stall_left;
        if (hold_off_seq != seen_seq) begin
            seen_seq   = hold_off_seq;
            stall_left = hold_off_len;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each result transfer with the oldest outstanding prediction
    always @(posedge aclk) begin : check_results
        list_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected result", m_tdata[31:0], 32'h0);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[31:0] !== want.read_value)
                    flag_mismatch("read_value", m_tdata[31:0], want.read_value);
                if (m_tdata[36:32] !== want.found_position)
                    flag_mismatch("found_position", 32'(m_tdata[36:32]),
                                  32'(want.found_position));
                if (m_tdata[37] !== want.present)
                    flag_mismatch("present", 32'(m_tdata[37]), 32'(want.present));
                if (m_tdata[42:38] !== want.count)
                    flag_mismatch("count", 32'(m_tdata[42:38]), 32'(want.count));
                if (m_tdata[43] !== want.empty_res)
                    flag_mismatch("empty_res", 32'(m_tdata[43]), 32'(want.empty_res));
                if (m_tdata[45:44] !== want.status)
                    flag_mismatch("status", 32'(m_tdata[45:44]), 32'(want.status));
            end
        end
    end

    initial begin
        send_idle_pct = 18;
        recv_idle_pct = 70;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_list();
        test_insert_positions();
        test_read_and_lookup();
        test_remove_positions();
        test_unused_funcs();

        test_list_traffic(570, 18, 70);
        test_list_traffic(570, 70, 18);
        test_list_traffic(570, 0, 0);
        test_backpressure();

        s_tvalid <= 1'b0;
        recv_idle_pct = 0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Stop a hung run
    initial begin
        #8_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
